// ----- rtl/core/ist_pkg.sv -----
package ist_pkg;

  localparam int ROWS_DEF = 64;
  localparam int DIM_DEF  = 16;

  localparam logic [1:0] OP_WR_COL = 2'd0;
  localparam logic [1:0] OP_WR_LEN = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_GET_V,
    SQ_GET_U,
    SQ_GET_LEN,
    SQ_CHK_LEN,
    SQ_FIND_U,
    SQ_FIND_V,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } seq_stat_t;

endpackage

// ----- rtl/core/ist_ram.sv -----
module ist_ram import ist_pkg::*; #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/ist_seq.sv -----
module ist_seq import ist_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int DIM  = DIM_DEF,
  localparam int RW  = $clog2(ROWS),
  localparam int PW  = $clog2(DIM),
  localparam int LW  = $clog2(DIM + 1),
  localparam int AW  = $clog2(ROWS * DIM)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          zero,
  input  logic [RW-1:0] m,
  input  logic [PW-1:0] n,
  input  logic          out_free,
  input  logic [7:0]    inc_rdata,
  input  logic [LW-1:0] len_rdata,
  output logic [AW-1:0] inc_addr,
  output logic [RW-1:0] len_addr,
  output seq_stat_t     stat
);

  seq_state_t state, state_next;

  logic [RW-1:0] m_q, i;
  logic [PW-1:0] n_q, l, j;
  logic [7:0]    u_q, v_q;
  logic [LW-1:0] len_q;
  logic          found;

  logic [LW-1:0] jn;
  logic          u_hit, v_hit, row_more, pos_more, len_short;
  logic [RW-1:0] row_sel;
  logic [PW-1:0] pos_sel;

  assign jn        = LW'(j) + LW'(1);
  assign u_hit     = (inc_rdata == u_q);
  assign v_hit     = (inc_rdata == v_q);
  assign row_more  = ((RW + 1)'(i) + (RW + 1)'(1)) < (RW + 1)'(m_q);
  assign pos_more  = ((PW + 1)'(l) + (PW + 1)'(1)) < (PW + 1)'(n_q);
  assign len_short = len_rdata < LW'(2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE: begin
        if (start) begin
          state_next = zero ? SQ_DONE : SQ_GET_V;
        end
      end
      SQ_GET_V:   state_next = SQ_GET_U;
      SQ_GET_U:   state_next = SQ_GET_LEN;
      SQ_GET_LEN: state_next = SQ_CHK_LEN;
      SQ_CHK_LEN: begin
        if (!len_short) begin
          state_next = SQ_FIND_U;
        end else if (row_more) begin
          state_next = SQ_GET_LEN;
        end else if (pos_more) begin
          state_next = SQ_GET_U;
        end else begin
          state_next = SQ_DONE;
        end
      end
      SQ_FIND_U: begin
        if (u_hit && jn < len_q) begin
          state_next = SQ_FIND_V;
        end else if (!u_hit && jn < len_q - LW'(1)) begin
          state_next = SQ_FIND_U;
        end else if (row_more) begin
          state_next = SQ_GET_LEN;
        end else if (pos_more) begin
          state_next = SQ_GET_U;
        end else begin
          state_next = SQ_DONE;
        end
      end
      SQ_FIND_V: begin
        if (v_hit) begin
          state_next = SQ_DONE;
        end else if (jn < len_q) begin
          state_next = SQ_FIND_V;
        end else if (row_more) begin
          state_next = SQ_GET_LEN;
        end else if (pos_more) begin
          state_next = SQ_GET_U;
        end else begin
          state_next = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (out_free) begin
          state_next = SQ_IDLE;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // outputs: read addresses and status
  always_comb begin
    row_sel    = i;
    pos_sel    = '0;
    len_addr   = i;
    stat.busy  = (state != SQ_IDLE);
    stat.done  = 1'b0;
    stat.found = found;
    unique case (state)
      SQ_IDLE:    ;
      SQ_GET_V: begin
        row_sel = m_q;
        pos_sel = n_q;
      end
      SQ_GET_U: begin
        row_sel = m_q;
        pos_sel = l;
      end
      SQ_GET_LEN: ;
      SQ_CHK_LEN: pos_sel = '0;
      SQ_FIND_U,
      SQ_FIND_V:  pos_sel = PW'(jn);
      SQ_DONE:    stat.done = out_free;
      default:    ;
    endcase
  end

  assign inc_addr = AW'(row_sel) * AW'(DIM) + AW'(pos_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (state == SQ_IDLE && start) begin
        found <= 1'b0;
      end else if (state == SQ_FIND_V && v_hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SQ_IDLE: begin
        m_q <= m;
        n_q <= n;
        i   <= '0;
        l   <= '0;
      end
      SQ_GET_U: begin
        if (l == '0) begin
          v_q <= inc_rdata;
        end
      end
      SQ_GET_LEN: begin
        if (i == '0) begin
          u_q <= inc_rdata;
        end
      end
      default: ;
    endcase

    case (state_next)
      SQ_FIND_U,
      SQ_FIND_V: begin
        if (state == SQ_CHK_LEN) begin
          j <= '0;
        end else begin
          j <= PW'(jn);
        end
      end
      default: ;
    endcase

    if (state == SQ_CHK_LEN) begin
      len_q <= len_rdata;
    end

    // advance to the next earlier row, or to the next position of row m
    if ((state == SQ_CHK_LEN || state == SQ_FIND_U || state == SQ_FIND_V)
        && state_next == SQ_GET_LEN) begin
      i <= i + RW'(1);
    end
    if ((state == SQ_CHK_LEN || state == SQ_FIND_U || state == SQ_FIND_V)
        && state_next == SQ_GET_U) begin
      i <= '0;
      l <= l + PW'(1);
    end
  end

endmodule

// ----- rtl/core/incidence_square_test.sv -----
// Incidence table with a square query.
//
// Input channel (in_valid / in_stall): operation, row, position, value.
//   A column write or a row length write is taken without a stall and gives
//   no result. A square query gives one result item on square_found.
// Output channel (out_valid / out_stall): one registered result item.
//
// A query is worked through by one sequencer reading the table one entry
// per cycle over a single RAM port; in_stall stays high meanwhile. A query
// naming row 0, position 0, or a slot out of range answers without reading
// the table.
// The result waits in the output register; while the receiver stalls,
// the block still takes writes, and a finished query holds until the
// output register is free.
// Reset clears all row lengths to zero (per-row valid bits) and empties
// the output register. Column entries hold nothing defined until written.
module incidence_square_test import ist_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int DIM  = DIM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [5:0] row,
  input  logic [3:0] position,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       square_found
);

  localparam int RW = $clog2(ROWS);
  localparam int PW = $clog2(DIM);
  localparam int LW = $clog2(DIM + 1);
  localparam int AW = $clog2(ROWS * DIM);

  seq_stat_t     stat;
  logic          accept, row_ok, pos_ok, zero, out_free;
  logic [RW-1:0] row_idx, len_raddr, len_addr;
  logic [PW-1:0] pos_idx;
  logic [AW-1:0] seq_addr, inc_addr;
  logic [7:0]    inc_rdata;
  logic [LW-1:0] len_wdata, len_rdata, len_eff;
  logic          inc_we, len_we, len_vld_q;
  logic [ROWS-1:0] len_valid;

  assign in_stall = stat.busy;
  assign accept   = in_valid && !in_stall;
  assign row_ok   = int'(row) < ROWS;
  assign pos_ok   = int'(position) < DIM;
  assign row_idx  = RW'(row);
  assign pos_idx  = PW'(position);
  assign zero     = (row == '0) || (position == '0) || !row_ok || !pos_ok;
  assign out_free = !out_valid || !out_stall;

  assign inc_we   = accept && operation == OP_WR_COL && row_ok && pos_ok;
  assign len_we   = accept && operation == OP_WR_LEN && row_ok;
  // saturate long lengths
  assign len_wdata = (int'(value) > DIM) ? LW'(DIM) : LW'(value);

  assign inc_addr = stat.busy ? seq_addr
                              : AW'(row_idx) * AW'(DIM) + AW'(pos_idx);
  assign len_addr = stat.busy ? len_raddr : row_idx;
  assign len_eff  = len_vld_q ? len_rdata : '0;

  ist_ram #(.W(8), .D(ROWS * DIM)) u_inc_ram (
    .clk   (clk),
    .we    (inc_we),
    .addr  (inc_addr),
    .wdata (value),
    .rdata (inc_rdata)
  );

  ist_ram #(.W(LW), .D(ROWS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .addr  (len_addr),
    .wdata (len_wdata),
    .rdata (len_rdata)
  );

  ist_seq #(.ROWS(ROWS), .DIM(DIM)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && operation == OP_QUERY),
    .zero      (zero),
    .m         (row_idx),
    .n         (pos_idx),
    .out_free  (out_free),
    .inc_rdata (inc_rdata),
    .len_rdata (len_eff),
    .inc_addr  (seq_addr),
    .len_addr  (len_raddr),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
    end else if (len_we) begin
      len_valid[row_idx] <= 1'b1;
    end
    len_vld_q <= len_valid[len_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (stat.done) begin
      square_found <= stat.found;
    end
  end

endmodule

// ----- rtl/core/ist_checker.sv -----
module ist_checker import ist_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic       square_found
);

  // an accepted query holds the input side in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_QUERY) |=> in_stall)
    else $error("query accepted without going busy");

  // writes and unused operations never hold the input side
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation != OP_QUERY) |=> !in_stall)
    else $error("write left the block busy");

  // a result only ever follows query work
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item without a query in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(square_found)))
    else $error("stalled result item changed");

endmodule

bind incidence_square_test ist_checker u_ist_checker (.*);

// ----- tb/sv/tb_incidence_square_test.sv -----
class square_scoreboard;
  bit [7:0] col_table [ist_pkg::ROWS_DEF][ist_pkg::DIM_DEF];
  bit [4:0] len_table [ist_pkg::ROWS_DEF];
  bit       pending_answers [$];
  int       errors;

  function new();
    errors = 0;
  endfunction

  // Does some earlier row hold column u from before position n of row m,
  // followed later in that row by the column v at position n?
  function bit square_exists(int m, int n);
    bit [7:0] u;
    bit [7:0] v;
    int       len;
    int       j;
    bit       hit;
    if (m == 0 || n == 0 || m >= ist_pkg::ROWS_DEF || n >= ist_pkg::DIM_DEF) return 1'b0;
    v = col_table[m][n];
    for (int l = 0; l < n; l++) begin
      u = col_table[m][l];
      for (int i = 0; i < m; i++) begin
        len = len_table[i];
        hit = 1'b0;
        for (j = 0; j < len - 1; j++) begin
          if (col_table[i][j] == u) begin
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          for (j = j + 1; j < len; j++) begin
            if (col_table[i][j] == v) return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function void note_item(logic [1:0] op, logic [5:0] r, logic [3:0] p, logic [7:0] v);
    case (op)
      ist_pkg::OP_WR_COL: col_table[r][p] = v;
      ist_pkg::OP_WR_LEN: len_table[r] = (v > ist_pkg::DIM_DEF) ? 5'(ist_pkg::DIM_DEF) : v[4:0];
      ist_pkg::OP_QUERY:  pending_answers = {pending_answers, square_exists(int'(r), int'(p))};
      default: ;
    endcase
  endfunction

  function void check_answer(logic got);
    bit want;
    if (pending_answers.size() == 0) begin
      $error("square_found: result with no query waiting, actual %0b", got);
      errors++;
    end else begin
      want = pending_answers.pop_front();
      if (got !== want) begin
        $error("square_found mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    end
  endfunction

  function int outstanding();
    return pending_answers.size();
  endfunction
endclass

module tb_incidence_square_test import ist_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TOTAL = 580;
  // Allow for every item being the slowest legal query, plus the longest
  // gaps and stalls, several times over.
  localparam int CYCLE_LIMIT = 40_000_000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] operation = OP_WR_COL;
  logic [5:0] row = '0;
  logic [3:0] position = '0;
  logic [7:0] value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       square_found;

  square_scoreboard answers = new();
  bit col_written [ROWS_DEF][DIM_DEF];
  int sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  incidence_square_test DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .row(row), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .square_found(square_found)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_row();
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, 11);
    return $urandom_range(0, 63);
  endfunction

  // Count of leading column entries of a row that hold a written value.
  function automatic int written_prefix(int r);
    int k;
    k = 0;
    while (k < DIM_DEF && col_written[r][k]) k++;
    return k;
  endfunction

  task automatic send_item(logic [1:0] op, int r, int p, int v);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    row       <= 6'(r);
    position  <= 4'(p);
    value     <= 8'(v);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    answers.note_item(op, 6'(r), 4'(p), 8'(v));
    if (op == OP_WR_COL) col_written[r][p] = 1'b1;
    if (op != OP_UNUSED) sent++;
  endtask

  // Output side: alternate free and stalled stretches of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      if ($urandom_range(0, 99) < 3) out_calm = !out_calm;
      stall_left = pick_gap(out_calm);
      if (stall_left > 0) out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) answers.check_answer(square_found);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int r;
    int m;
    int p;
    int v;
    int filled;
    int eff;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero row or position answers false without reading the table
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 9, 0);
    send_item(OP_QUERY, 7, 0, 0);
    send_item(OP_UNUSED, 63, 15, 255);
    send_item(OP_WR_COL, 0, 0, 3);
    send_item(OP_WR_COL, 0, 1, 5);
    send_item(OP_WR_COL, 0, 2, 0);
    send_item(OP_WR_LEN, 0, 0, 3);
    send_item(OP_WR_COL, 1, 0, 5);
    send_item(OP_WR_COL, 1, 1, 0);
    send_item(OP_QUERY, 1, 1, 0);
    // v sits before u in row 0: no square
    send_item(OP_WR_COL, 1, 2, 3);
    send_item(OP_QUERY, 1, 2, 0);
    // length one and length zero rows are skipped
    send_item(OP_WR_LEN, 0, 0, 1);
    send_item(OP_QUERY, 1, 1, 0);
    send_item(OP_WR_LEN, 0, 0, 0);
    send_item(OP_QUERY, 1, 2, 0);
    send_item(OP_WR_COL, 2, 0, 255);
    send_item(OP_WR_COL, 2, 1, 0);
    send_item(OP_WR_LEN, 1, 0, 3);
    // row 63 is never scanned, so a saturated length there is safe
    send_item(OP_WR_LEN, 63, 15, 255);
    send_item(OP_QUERY, 2, 1, 0);
    send_item(OP_QUERY, 63, 0, 0);
    send_item(OP_WR_COL, 5, 15, 255);

    while (sent < ITEM_TOTAL) begin
      if ($urandom_range(0, 99) < 3) in_calm = !in_calm;
      r = $urandom_range(0, 99);
      m = pick_row();
      filled = written_prefix(m);
      if (r < 40) begin
        if (filled < DIM_DEF && $urandom_range(0, 99) < 65) p = filled;
        else p = $urandom_range(0, 15);
        // a small column pool makes shared columns, hence squares, likely
        if ($urandom_range(0, 99) < 75) v = $urandom_range(0, 5);
        else v = $urandom_range(0, 255);
        send_item(OP_WR_COL, m, p, v);
      end else if (r < 55) begin
        p = $urandom_range(0, 15);
        r = $urandom_range(0, 99);
        if (r < 10 || (filled == DIM_DEF && r < 40)) v = $urandom_range(17, 255);
        else if (r < 20) v = $urandom_range(0, 1);
        else v = $urandom_range(2, 16);
        eff = (v > DIM_DEF) ? DIM_DEF : v;
        // keep every entry a later query may scan already written
        if (eff >= 2 && filled < eff && m != ROWS_DEF - 1) begin
          if (filled >= 2) v = $urandom_range(2, filled);
          else v = $urandom_range(0, 1);
        end
        send_item(OP_WR_LEN, m, p, v);
      end else if (r < 95) begin
        p = $urandom_range(0, 15);
        if (m != 0 && p != 0 && filled < p + 1) begin
          if (filled >= 2) p = $urandom_range(1, filled - 1);
          else p = 0;
        end
        send_item(OP_QUERY, m, p, $urandom_range(0, 255));
      end else begin
        send_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 255));
      end
    end
    in_valid <= 1'b0;

    while (answers.outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (answers.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
